/* hdl/incremental_permutation_shuffler_top_macros.svh */
// Assertion macros used by the shuffler sequencer.
`ifndef INCREMENTAL_PERMUTATION_SHUFFLER_TOP_MACROS_SVH
`define INCREMENTAL_PERMUTATION_SHUFFLER_TOP_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication, disabled while reset is asserted.
`define IPS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("shuffler assertion failed");
// Next-cycle implication, disabled while reset is asserted.
`define IPS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("shuffler assertion failed");
`else
`define IPS_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define IPS_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

/* hdl/ips_pkg.sv */
// Types and constants of the incremental permutation shuffler.
`timescale 1ns / 1ps
`default_nettype none

package ips_pkg;

	// Request kinds
	localparam logic KIND_NEXT = 1'b0;
	localparam logic KIND_SET  = 1'b1;

	// Error codes
	localparam logic [1:0] ERR_OK        = 2'd0;
	localparam logic [1:0] ERR_EXHAUSTED = 2'd1;
	localparam logic [1:0] ERR_RANGE     = 2'd2;
	localparam logic [1:0] ERR_EMITTED   = 2'd3;

	localparam int CFG_W = 11;
	localparam int VAL_W = 10;

	typedef struct packed {
		logic             kind;
		logic [VAL_W-1:0] random_position;
		logic [VAL_W-1:0] requested_value;
	} in_t;

	typedef struct packed {
		logic [VAL_W-1:0] emitted_value;
		logic [1:0]       error;
	} out_t;

	// Result handed from the sequencer to the output register
	typedef struct packed {
		logic valid;
		out_t data;
	} res_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_CHK,
		ST_SRCH,
		ST_RDCUR,
		ST_WRPOS,
		ST_WRCUR
	} seq_state_t;

endpackage

`default_nettype wire

/* hdl/incremental_permutation_shuffler_top.sv */
// After accept, a next request passes ST_RDCUR, ST_WRPOS and ST_WRCUR, and its result
// enters the output register; set_next found at its own index passes ST_CHK, ST_WRPOS
// and ST_WRCUR; set_next by search adds ST_SRCH, scanning from the cursor. Errors come
// from ST_IDLE, ST_CHK or ST_SRCH. One request at a time; the next is accepted once the
// result is registered and the output register is free. Reset and every active_count
// write clears the table to identity, with requests stalled; the cursor returns to zero.
`timescale 1ns / 1ps
`default_nettype none

module incremental_permutation_shuffler_top
	import ips_pkg::*;
#(
	parameter int MAX_COUNT = 1024
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire in_t              in_data,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output out_t                  out_data,
	input  wire logic             cfg_we,
	input  wire logic [CFG_W-1:0] cfg_wdata
);

	localparam int AW = $clog2(MAX_COUNT);
	localparam int CW = $clog2(MAX_COUNT + 1);
	localparam int WW = (CW > CFG_W) ? CW : CFG_W;
	localparam logic [CW-1:0] RST_COUNT = CW'((MAX_COUNT < 1024) ? MAX_COUNT : 1024);

	logic [CW-1:0] count_q;
	logic [WW-1:0] cfg_w, clamp_w;
	logic          out_valid_q;
	out_t          out_data_q;
	logic          out_busy;
	res_t          res;
	logic          ram_we;
	logic [AW-1:0] ram_waddr, ram_wdata, ram_raddr, ram_rdata;

	// Effective count, clamped to [2, MAX_COUNT]
	assign cfg_w = WW'(cfg_wdata);
	always_comb begin
		if (cfg_w < WW'(2)) begin
			clamp_w = WW'(2);
		end else if (cfg_w > WW'(MAX_COUNT)) begin
			clamp_w = WW'(MAX_COUNT);
		end else begin
			clamp_w = cfg_w;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= RST_COUNT;
		end else if (cfg_we) begin
			count_q <= clamp_w[CW-1:0];
		end
	end

	// Output register
	assign out_busy = out_valid_q && out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res.valid) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.valid) begin
			out_data_q <= res.data;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	ips_seq #(
		.MAX_COUNT (MAX_COUNT),
		.AW        (AW),
		.CW        (CW)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.count     (count_q),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_busy  (out_busy),
		.res       (res),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata)
	);

	ips_ram #(
		.WIDTH (AW),
		.DEPTH (MAX_COUNT)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

endmodule

`default_nettype wire

/* hdl/ips_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module ips_ram #(
	parameter int WIDTH = 10,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

/* hdl/ips_seq.sv */
// Sequencer: read-modify-write of the permutation table, search and clear pass.
`timescale 1ns / 1ps
`default_nettype none
`include "incremental_permutation_shuffler_top_macros.svh"

module ips_seq
	import ips_pkg::*;
#(
	parameter int MAX_COUNT = 1024,
	parameter int AW        = $clog2(MAX_COUNT),
	parameter int CW        = $clog2(MAX_COUNT + 1)
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cfg_we,
	input  wire logic [CW-1:0] count,
	input  wire logic          in_valid,
	output logic               in_stall,
	input  wire in_t           in_data,
	input  wire logic          out_busy,
	output res_t               res,
	output logic               ram_we,
	output logic [AW-1:0]      ram_waddr,
	output logic [AW-1:0]      ram_wdata,
	output logic [AW-1:0]      ram_raddr,
	input  wire logic [AW-1:0] ram_rdata
);

	// Common compare width for fields, counts and table values
	localparam int WW = (CW > CFG_W) ? CW : CFG_W;

	seq_state_t     state_q, state_d;
	logic [CW-1:0]  cursor_q;
	logic [AW-1:0]  clr_q;
	logic [AW-1:0]  pos_q, pos_d;
	logic [AW-1:0]  val_q, val_d;
	logic [AW-1:0]  req_q, req_d;
	logic [CW-1:0]  idx_q, idx_d;
	logic [CW-1:0]  idx_nx;
	logic           cur_inc;
	logic           clr_inc;
	logic [WW-1:0]  cur_w, cnt_w, pos_in_w, val_in_w, rd_w, req_w, idx_nx_w, ev_w;

	assign cur_w    = WW'(cursor_q);
	assign cnt_w    = WW'(count);
	assign pos_in_w = WW'(in_data.random_position);
	assign val_in_w = WW'(in_data.requested_value);
	assign rd_w     = WW'(ram_rdata);
	assign req_w    = WW'(req_q);
	assign idx_nx   = idx_q + 1'b1;
	assign idx_nx_w = WW'(idx_nx);
	assign ev_w     = WW'(val_q);

	// Next state, memory accesses and result
	always_comb begin
		state_d   = state_q;
		in_stall  = 1'b1;
		res       = '0;
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = '0;
		ram_raddr = '0;
		pos_d     = pos_q;
		val_d     = val_q;
		req_d     = req_q;
		idx_d     = idx_q;
		cur_inc   = 1'b0;
		clr_inc   = 1'b0;

		case (state_q)
			ST_CLEAR: begin
				// identity fill, one entry a cycle
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = clr_q;
				clr_inc   = 1'b1;
				if (clr_q == AW'(MAX_COUNT - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_stall = out_busy || cfg_we;
				if (in_valid && !in_stall) begin
					if (cur_w >= cnt_w) begin
						res.valid      = 1'b1;
						res.data.error = ERR_EXHAUSTED;
					end else if (in_data.kind == KIND_NEXT) begin
						if (pos_in_w < cur_w || pos_in_w >= cnt_w) begin
							res.valid      = 1'b1;
							res.data.error = ERR_RANGE;
						end else begin
							ram_raddr = pos_in_w[AW-1:0];
							pos_d     = pos_in_w[AW-1:0];
							state_d   = ST_RDCUR;
						end
					end else begin
						if (val_in_w >= cnt_w) begin
							res.valid      = 1'b1;
							res.data.error = ERR_RANGE;
						end else begin
							ram_raddr = val_in_w[AW-1:0];
							req_d     = val_in_w[AW-1:0];
							state_d   = ST_CHK;
						end
					end
				end
			end
			ST_RDCUR: begin
				// table[pos] arrives; fetch table[cursor]
				val_d     = ram_rdata;
				ram_raddr = cursor_q[AW-1:0];
				state_d   = ST_WRPOS;
			end
			ST_CHK: begin
				// does the value still sit at its own index?
				if (rd_w == req_w) begin
					if (req_w < cur_w) begin
						res.valid      = 1'b1;
						res.data.error = ERR_EMITTED;
						state_d        = ST_IDLE;
					end else begin
						pos_d     = req_q;
						val_d     = req_q;
						ram_raddr = cursor_q[AW-1:0];
						state_d   = ST_WRPOS;
					end
				end else begin
					ram_raddr = cursor_q[AW-1:0];
					idx_d     = cursor_q;
					state_d   = ST_SRCH;
				end
			end
			ST_SRCH: begin
				// one entry compared per cycle, next address issued in parallel
				if (rd_w == req_w) begin
					pos_d     = idx_q[AW-1:0];
					val_d     = req_q;
					ram_raddr = cursor_q[AW-1:0];
					state_d   = ST_WRPOS;
				end else if (idx_nx_w >= cnt_w) begin
					res.valid      = 1'b1;
					res.data.error = ERR_EMITTED;
					state_d        = ST_IDLE;
				end else begin
					ram_raddr = idx_nx[AW-1:0];
					idx_d     = idx_nx;
				end
			end
			ST_WRPOS: begin
				// table[pos] <= table[cursor]
				ram_we    = 1'b1;
				ram_waddr = pos_q;
				ram_wdata = ram_rdata;
				state_d   = ST_WRCUR;
			end
			ST_WRCUR: begin
				// table[cursor] <= emitted value, advance cursor
				ram_we                 = 1'b1;
				ram_waddr              = cursor_q[AW-1:0];
				ram_wdata              = val_q;
				cur_inc                = 1'b1;
				res.valid              = 1'b1;
				res.data.emitted_value = ev_w[VAL_W-1:0];
				res.data.error         = ERR_OK;
				state_d                = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase

		// register write restarts the shuffle
		if (cfg_we) begin
			state_d = ST_CLEAR;
		end
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CLEAR;
			cursor_q <= '0;
			clr_q    <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				cursor_q <= '0;
				clr_q    <= '0;
			end else begin
				if (cur_inc) begin
					cursor_q <= cursor_q + 1'b1;
				end
				if (clr_inc) begin
					clr_q <= clr_q + 1'b1;
				end
			end
		end
	end

	// Per-request working registers
	always_ff @(posedge clk) begin
		pos_q <= pos_d;
		val_q <= val_d;
		req_q <= req_d;
		idx_q <= idx_d;
	end

	`IPS_ASSERT_IMP(a_cursor_bound, clk, arst_n, 1'b1, WW'(cursor_q) <= WW'(count))
	`IPS_ASSERT_IMP(a_res_slot_free, clk, arst_n, res.valid, !out_busy)
	`IPS_ASSERT_NXT(a_cursor_step, clk, arst_n, state_q == ST_WRCUR && !cfg_we, cursor_q == $past(cursor_q) + 1'b1)
	`IPS_ASSERT_IMP(a_no_write_in_lookup, clk, arst_n, state_q == ST_CHK || state_q == ST_SRCH, !ram_we)

endmodule

`default_nettype wire
